// File: design/addressable_led_strip_driver_core_macros.svh
// assertion macros for the led strip driver core
// expects clk and rst_n in the scope where the macros are used
`ifndef ADDRESSABLE_LED_STRIP_DRIVER_CORE_MACROS_SVH
`define ADDRESSABLE_LED_STRIP_DRIVER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ALSD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ALSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/alsd_pkg.sv
// shared types and constants of the led strip driver core
// no dependencies
`default_nettype none

package alsd_pkg;

    // input op codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_START = 2'd3;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_LED_COUNT       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH_TICKS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW_TICKS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH_TICKS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW_TICKS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_TICKS     = 3'd5;

    // configuration reset values
    localparam logic [8:0]  LED_COUNT_RST       = 9'd1;
    localparam logic [7:0]  ONE_HIGH_TICKS_RST  = 8'd20;
    localparam logic [7:0]  ONE_LOW_TICKS_RST   = 8'd5;
    localparam logic [7:0]  ZERO_HIGH_TICKS_RST = 8'd5;
    localparam logic [7:0]  ZERO_LOW_TICKS_RST  = 8'd20;
    localparam logic [15:0] RESET_TICKS_RST     = 16'd6000;

    // live timing configuration seen by the frame sequencer
    typedef struct packed {
        logic [8:0]  led_count;
        logic [7:0]  one_high_ticks;
        logic [7:0]  one_low_ticks;
        logic [7:0]  zero_high_ticks;
        logic [7:0]  zero_low_ticks;
        logic [15:0] reset_ticks;
    } timing_cfg_t;

    // one result item
    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic frame_done;
    } result_t;

endpackage

`default_nettype wire

// File: design/alsd_if.sv
// channel interfaces of the led strip driver core: items, results, config writes
// no dependencies
`default_nettype none

// input item channel
interface alsd_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  led_index;
    logic [23:0] color_rgb;

    modport source (output valid, output op, output led_index, output color_rgb,
                    input ready);
    modport sink   (input valid, input op, input led_index, input color_rgb,
                    output ready);
endinterface

// result item channel
interface alsd_result_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;
    logic frame_done;

    modport source (output valid, output pin_level, output busy_res, output frame_done,
                    input ready);
    modport sink   (input valid, input pin_level, input busy_res, input frame_done,
                    output ready);
endinterface

// configuration write channel
interface alsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/alsd_color_store.sv
// color store: one 24-bit color per led in a synchronous memory, with a fill sweep
// depends on alsd_pkg
`default_nettype none

module alsd_color_store
    import alsd_pkg::*;
#(
    parameter int MAX_LEDS = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  logic [((MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1)-1:0] wr_addr,
    input  logic [23:0] wr_data,
    input  logic fill_start,
    input  logic [23:0] fill_color,
    input  logic [((MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1)-1:0] rd_addr,
    output logic [23:0] rd_data,
    output logic sweeping
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);

    logic [23:0]   mem [MAX_LEDS];
    logic [23:0]   rd_data_reg;
    logic          sweep_reg;
    logic [AW-1:0] sweep_addr_reg;
    logic [23:0]   sweep_color_reg;

    // fill sweep control, also clears the store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg       <= 1'b1;
            sweep_addr_reg  <= '0;
            sweep_color_reg <= '0;
        end
        else if (fill_start)
        begin
            sweep_reg       <= 1'b1;
            sweep_addr_reg  <= '0;
            sweep_color_reg <= fill_color;
        end
        else if (sweep_reg)
        begin
            if (sweep_addr_reg == LAST_ADDR)
                sweep_reg <= 1'b0;
            else
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (sweep_reg)
            mem[sweep_addr_reg] <= sweep_color_reg;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign sweeping = sweep_reg;

endmodule

`default_nettype wire

// File: design/alsd_frame_seq.sv
// frame sequencer: leading low, bit pulses per led, closing low
// depends on alsd_pkg; prefetches colors from alsd_color_store ahead of use through its registered read
`default_nettype none

module alsd_frame_seq
    import alsd_pkg::*;
#(
    parameter int MAX_LEDS = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  timing_cfg_t cfg,
    input  logic tick_en,
    input  logic start_en,
    input  logic [23:0] rd_data,
    output logic [((MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1)-1:0] rd_addr,
    output logic [(($clog2(MAX_LEDS + 1) > 9) ? $clog2(MAX_LEDS + 1) : 9)-1:0] active_count,
    output logic busy,
    output result_t res
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int NW = $clog2(MAX_LEDS + 1);
    localparam int CW = (NW > 9) ? NW : 9;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_LEDS);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LEAD = 3'd1;
    localparam logic [2:0] PH_HIGH = 3'd2;
    localparam logic [2:0] PH_LOW  = 3'd3;
    localparam logic [2:0] PH_TAIL = 3'd4;

    logic [2:0]    phase_reg,   phase_next;
    logic [AW-1:0] led_ptr_reg, led_ptr_next;
    logic [4:0]    bit_ptr_reg, bit_ptr_next;
    logic [15:0]   tick_reg,    tick_next;
    logic [23:0]   shift_reg,   shift_next;
    logic          line_reg,    line_next;
    logic          done;

    logic [15:0]   tick_inc;
    logic [4:0]    bit_inc;
    logic [CW-1:0] led_following;
    logic [15:0]   reset_lim;
    logic [15:0]   high_lim;
    logic [15:0]   low_lim;
    logic [CW-1:0] led_count_ext;
    logic [23:0]   loaded_word;

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // effective count, clamped to the store depth
    assign led_count_ext = CW'(cfg.led_count);
    assign active_count  = (led_count_ext > MAX_COUNT) ? MAX_COUNT : led_count_ext;

    // pulse limits for the bit in flight
    assign tick_inc      = tick_reg + 16'd1;
    assign bit_inc       = bit_ptr_reg + 5'd1;
    assign led_following = CW'(led_ptr_reg) + CW'(1);
    assign reset_lim     = at_least_one(cfg.reset_ticks);
    assign high_lim      = at_least_one(shift_reg[23] ? {8'd0, cfg.one_high_ticks}
                                                      : {8'd0, cfg.zero_high_ticks});
    assign low_lim       = at_least_one(shift_reg[23] ? {8'd0, cfg.one_low_ticks}
                                                      : {8'd0, cfg.zero_low_ticks});

    // wire order green, red, blue
    assign loaded_word = {rd_data[15:8], rd_data[23:16], rd_data[7:0]};

    // prefetch address: the led that follows the one in flight
    always_comb
    begin
        unique case (phase_reg) inside
            PH_HIGH, PH_LOW:
                rd_addr = (led_following >= MAX_COUNT) ? '0 : led_following[AW-1:0];
            default:
                rd_addr = '0;
        endcase
    end

    // next state per accepted item
    always_comb
    begin
        phase_next   = phase_reg;
        led_ptr_next = led_ptr_reg;
        bit_ptr_next = bit_ptr_reg;
        tick_next    = tick_reg;
        shift_next   = shift_reg;
        line_next    = line_reg;
        done         = 1'b0;
        if (start_en)
        begin
            phase_next   = PH_LEAD;
            tick_next    = '0;
            led_ptr_next = '0;
            bit_ptr_next = '0;
            shift_next   = '0;
            line_next    = 1'b0;
        end
        else if (tick_en)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    line_next = 1'b0;
                    tick_next = tick_inc;
                    if (tick_inc >= reset_lim)
                    begin
                        tick_next    = '0;
                        led_ptr_next = '0;
                        if (active_count != '0)
                        begin
                            shift_next   = loaded_word;
                            bit_ptr_next = '0;
                            phase_next   = PH_HIGH;
                        end
                        else
                            phase_next = PH_TAIL;
                    end
                end
                PH_HIGH:
                begin
                    line_next = 1'b1;
                    tick_next = tick_inc;
                    if (tick_inc >= high_lim)
                    begin
                        tick_next  = '0;
                        phase_next = PH_LOW;
                    end
                end
                PH_LOW:
                begin
                    line_next = 1'b0;
                    tick_next = tick_inc;
                    if (tick_inc >= low_lim)
                    begin
                        tick_next    = '0;
                        bit_ptr_next = bit_inc;
                        shift_next   = {shift_reg[22:0], 1'b0};
                        phase_next   = PH_HIGH;
                        if (bit_inc >= 5'd24)
                        begin
                            if (led_following >= active_count)
                            begin
                                led_ptr_next = '0;
                                bit_ptr_next = '0;
                                phase_next   = PH_TAIL;
                            end
                            else
                            begin
                                led_ptr_next = led_following[AW-1:0];
                                shift_next   = loaded_word;
                                bit_ptr_next = '0;
                            end
                        end
                    end
                end
                PH_TAIL:
                begin
                    line_next = 1'b0;
                    tick_next = tick_inc;
                    if (tick_inc >= reset_lim)
                    begin
                        tick_next  = '0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    line_next  = 1'b0;
                end
            endcase
        end
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            led_ptr_reg <= '0;
            bit_ptr_reg <= '0;
            tick_reg    <= '0;
            shift_reg   <= '0;
            line_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            led_ptr_reg <= led_ptr_next;
            bit_ptr_reg <= bit_ptr_next;
            tick_reg    <= tick_next;
            shift_reg   <= shift_next;
            line_reg    <= line_next;
        end
    end

    // result of the item handled this cycle
    assign busy           = (phase_reg != PH_IDLE);
    assign res.pin_level  = line_next;
    assign res.busy_res   = (phase_next != PH_IDLE);
    assign res.frame_done = done;

endmodule

`default_nettype wire

// File: design/addressable_led_strip_driver_core.sv
// top level of the addressable led strip driver: config registers, item decode,
// result register; depends on alsd_pkg, alsd_if, alsd_color_store, alsd_frame_seq
//
// Usage:
//   item   : one transaction per op (tick, set one led, fill all, start frame).
//   result : exactly one transaction per item, giving the line level, busy and
//            frame done after that item.
//   cfg    : register writes, always ready, index 0..5 in register order.
// Latency: the result of an item is offered the cycle after it is accepted.
// Throughput: one item per cycle for tick, set and start ops; the result register
//   lets the next item in while the previous result is taken in the same cycle.
// A fill op starts a sweep over the color memory, one entry per cycle, so the
//   item channel is held off after it until the sweep has covered every entry.
// Reset: registers take their reset values and the same sweep clears the color
//   memory with zero, so no item is accepted after reset until that sweep ends.
// Stall: if the result is not taken, the item channel holds off; frame timing
//   only advances on accepted tick items, so stalls never bend pulse widths.
`default_nettype none
`include "addressable_led_strip_driver_core_macros.svh"

module addressable_led_strip_driver_core
    import alsd_pkg::*;
#(
    parameter int MAX_LEDS = 256
) (
    input logic          clk,
    input logic          rst_n,
    alsd_item_if.sink    item,
    alsd_result_if.source result,
    alsd_cfg_if.sink     cfg
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int NW = $clog2(MAX_LEDS + 1);
    localparam int CW = (NW > 9) ? NW : 9;

    timing_cfg_t   cfg_reg;
    result_t       res;
    result_t       res_reg;
    logic          out_valid_reg;

    logic          item_acc;
    logic          seq_busy;
    logic          sweeping;
    logic          tick_en;
    logic          start_en;
    logic          set_en;
    logic          fill_en;
    logic [AW-1:0] rd_addr;
    logic [23:0]   rd_data;
    logic [CW-1:0] active_count;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.led_count       <= LED_COUNT_RST;
            cfg_reg.one_high_ticks  <= ONE_HIGH_TICKS_RST;
            cfg_reg.one_low_ticks   <= ONE_LOW_TICKS_RST;
            cfg_reg.zero_high_ticks <= ZERO_HIGH_TICKS_RST;
            cfg_reg.zero_low_ticks  <= ZERO_LOW_TICKS_RST;
            cfg_reg.reset_ticks     <= RESET_TICKS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LED_COUNT:       cfg_reg.led_count       <= cfg.data[8:0];
                REG_ONE_HIGH_TICKS:  cfg_reg.one_high_ticks  <= cfg.data[7:0];
                REG_ONE_LOW_TICKS:   cfg_reg.one_low_ticks   <= cfg.data[7:0];
                REG_ZERO_HIGH_TICKS: cfg_reg.zero_high_ticks <= cfg.data[7:0];
                REG_ZERO_LOW_TICKS:  cfg_reg.zero_low_ticks  <= cfg.data[7:0];
                REG_RESET_TICKS:     cfg_reg.reset_ticks     <= cfg.data;
                default:             ;
            endcase
        end
    end

    // item handshake and op decode; edits and starts only while idle
    assign item.ready = !sweeping && (!out_valid_reg || result.ready);
    assign item_acc   = item.valid && item.ready;
    assign tick_en    = item_acc && (item.op == OP_TICK);
    assign start_en   = item_acc && (item.op == OP_START) && !seq_busy;
    assign fill_en    = item_acc && (item.op == OP_FILL) && !seq_busy;
    assign set_en     = item_acc && (item.op == OP_SET) && !seq_busy
                        && (CW'(item.led_index) < active_count);

    // color memory
    alsd_color_store #(
        .MAX_LEDS (MAX_LEDS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (set_en),
        .wr_addr    (AW'(item.led_index)),
        .wr_data    (item.color_rgb),
        .fill_start (fill_en),
        .fill_color (item.color_rgb),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .sweeping   (sweeping)
    );

    // frame timing
    alsd_frame_seq #(
        .MAX_LEDS (MAX_LEDS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .tick_en      (tick_en),
        .start_en     (start_en),
        .rd_data      (rd_data),
        .rd_addr      (rd_addr),
        .active_count (active_count),
        .busy         (seq_busy),
        .res          (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (item_acc)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
            res_reg <= res;
    end

    assign result.valid      = out_valid_reg;
    assign result.pin_level  = res_reg.pin_level;
    assign result.busy_res   = res_reg.busy_res;
    assign result.frame_done = res_reg.frame_done;

    // checks
    `ALSD_ASSERT_NEXT(a_fill_holds_off_items, fill_en, !item.ready, "fill did not stall items")
    `ALSD_ASSERT_IMPLIES(a_done_ends_busy, result.valid && result.frame_done, !result.busy_res, "frame done while busy")
    `ALSD_ASSERT_IMPLIES(a_high_only_in_frame, result.valid && result.pin_level, result.busy_res, "line high outside a frame")

endmodule

`default_nettype wire
